FILE: sv/assert_macros.svh
// shared assertion macros, sampled on the rising edge of clk, off while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: sv/ttm_pkg.sv
package ttm_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int SAMPLE_BITS = 16;
	localparam int RUN_BITS    = 4;
	localparam int SUM_BITS    = COUNT_BITS + SAMPLE_BITS;
	localparam int STEP_BITS   = $clog2(SUM_BITS + 1);
	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [RUN_BITS-1:0]   RUN_MAX   = {RUN_BITS{1'b1}};

	// register reset values
	localparam logic signed [SAMPLE_BITS-1:0] LIMIT_RESET = SAMPLE_BITS'(1600);
	localparam logic signed [SAMPLE_BITS-1:0] PMIN_RESET  = -SAMPLE_BITS'(240);
	localparam logic [RUN_BITS-1:0]           TRIP_RESET  = RUN_BITS'(3);

	// register word indexes (byte address bits [3:2])
	localparam logic [1:0] REG_SAFE_LIMIT = 2'd0;
	localparam logic [1:0] REG_PHYS_MIN   = 2'd1;
	localparam logic [1:0] REG_TRIP_RUN   = 2'd2;

	// input ops
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// result status codes
	localparam logic [2:0] STAT_IN_RANGE = 3'd0;
	localparam logic [2:0] STAT_ALERT    = 3'd1;
	localparam logic [2:0] STAT_TRIP     = 3'd2;
	localparam logic [2:0] STAT_REJECTED = 3'd3;
	localparam logic [2:0] STAT_IGNORED  = 3'd4;
	localparam logic [2:0] STAT_REPORT   = 3'd5;

	typedef struct packed {
		logic                          op;
		logic signed [SAMPLE_BITS-1:0] temperature;
	} sample_t;

	typedef struct packed {
		logic [2:0]                    status;
		logic [RUN_BITS-1:0]           run_length;
		logic [COUNT_BITS-1:0]         sample_count;
		logic [COUNT_BITS-1:0]         above_count;
		logic signed [SAMPLE_BITS-1:0] highest;
		logic signed [SAMPLE_BITS-1:0] lowest;
		logic signed [SAMPLE_BITS-1:0] mean_value;
		logic                          have_samples;
		logic                          tripped;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_EMIT
	} state_t;

	// handshake between sequencer and divider
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

endpackage

FILE: sv/ttm_div.sv
module ttm_div import ttm_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  div_req_t                      req,
	input  logic signed [SUM_BITS-1:0]    dividend,
	input  logic [COUNT_BITS-1:0]         divisor,
	output div_rsp_t                      rsp,
	output logic signed [SAMPLE_BITS-1:0] quotient
);

	logic [STEP_BITS-1:0]  step_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  neg_q;
	logic [COUNT_BITS-1:0] div_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [SUM_BITS-1:0]   quo_q;
	logic [SUM_BITS-1:0]   mag;
	logic [COUNT_BITS:0]   shifted;
	logic [COUNT_BITS+1:0] diff;
	logic                  fits;
	logic [SUM_BITS-1:0]   signed_quo;

	// magnitude of the dividend, sign kept aside
	assign mag = dividend[SUM_BITS-1] ? (SUM_BITS'(0) - dividend) : dividend;

	// shared trial subtractor, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[SUM_BITS-1]};
	assign diff    = {1'b0, shifted} - {2'b00, div_q};
	assign fits    = !diff[COUNT_BITS+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= STEP_BITS'(SUM_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q - STEP_BITS'(1);
				if (step_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= dividend[SUM_BITS-1];
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	// truncation toward zero: divide magnitudes, then restore the sign
	assign signed_quo = neg_q ? (SUM_BITS'(0) - quo_q) : quo_q;
	assign quotient   = signed_quo[SAMPLE_BITS-1:0];
	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;

endmodule

FILE: sv/temperature_trip_monitor.sv
// Temperature trip monitor. An accepted sample transfer is evaluated in the next cycle and
// its result is loaded at that edge, provided the result register is free; the block is
// ready again once it is back in idle after the load, so it takes no new sample before the
// last one is loaded. A report with counted samples first starts a restoring divider that
// settles one quotient bit per cycle over the 40-bit running sum, waits for its done
// flag and loads once the result register is free. A report with no counted samples
// takes the sample path. While an untaken result sits in the result register, one more
// transfer is accepted and held before evaluation. Registers: safe limit at byte 0x0,
// physical minimum at 0x4, trip run length at 0x8; signed registers read back
// sign-extended. Write them only while no transfer is in flight.
`include "assert_macros.svh"

module temperature_trip_monitor import ttm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result
);

	state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] limit_q;
	logic signed [SAMPLE_BITS-1:0] pmin_q;
	logic [RUN_BITS-1:0]           trl_q;

	logic [COUNT_BITS-1:0]         cnt_q, cnt_d;
	logic [COUNT_BITS-1:0]         above_q, above_d;
	logic signed [SUM_BITS-1:0]    sum_q, sum_d;
	logic signed [SAMPLE_BITS-1:0] max_q, max_d;
	logic signed [SAMPLE_BITS-1:0] min_q, min_d;
	logic [RUN_BITS-1:0]           run_q, run_d;
	logic                          trip_q, trip_d;

	sample_t item_q;
	result_t out_q, out_d;
	logic    out_valid_q;

	logic                          wr_en;
	logic signed [SAMPLE_BITS-1:0] temp;
	logic                          take;
	logic                          hot;
	logic [RUN_BITS-1:0]           run_inc;
	logic [2:0]                    sample_status;
	logic                          slot_free;
	logic                          commit;
	logic                          load_out;
	div_req_t                      div_req;
	div_rsp_t                      div_rsp;
	logic signed [SAMPLE_BITS-1:0] quotient;

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			pmin_q  <= PMIN_RESET;
			trl_q   <= TRIP_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SAFE_LIMIT: limit_q <= pwdata[SAMPLE_BITS-1:0];
				REG_PHYS_MIN:   pmin_q  <= pwdata[SAMPLE_BITS-1:0];
				REG_TRIP_RUN:   trl_q   <= pwdata[RUN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SAFE_LIMIT: prdata = DATA_BITS'(limit_q);
			REG_PHYS_MIN:   prdata = DATA_BITS'(pmin_q);
			REG_TRIP_RUN:   prdata = DATA_BITS'(trl_q);
			default:        prdata = '0;
		endcase
	end

	// sample evaluation against current statistics
	assign temp    = item_q.temperature;
	assign take    = !trip_q && !(temp < pmin_q);
	assign hot     = temp > limit_q;
	assign run_inc = (run_q == RUN_MAX) ? run_q : run_q + RUN_BITS'(1);

	always_comb begin
		cnt_d         = cnt_q;
		sum_d         = sum_q;
		above_d       = above_q;
		max_d         = max_q;
		min_d         = min_q;
		run_d         = run_q;
		trip_d        = trip_q;
		sample_status = STAT_IN_RANGE;
		if (trip_q) begin
			sample_status = STAT_IGNORED;
		end else if (!take) begin
			sample_status = STAT_REJECTED;
		end else begin
			if (cnt_q == '0) begin
				max_d = temp;
				min_d = temp;
			end else begin
				if (temp > max_q) max_d = temp;
				if (temp < min_q) min_d = temp;
			end
			if (cnt_q != COUNT_MAX) begin
				cnt_d = cnt_q + COUNT_BITS'(1);
				sum_d = sum_q + SUM_BITS'(temp);
			end
			if (hot) begin
				if (above_q != COUNT_MAX) above_d = above_q + COUNT_BITS'(1);
				run_d = run_inc;
				if (run_inc >= trl_q) begin
					trip_d        = 1'b1;
					sample_status = STAT_TRIP;
				end else begin
					sample_status = STAT_ALERT;
				end
			end else begin
				run_d = '0;
			end
		end
	end

	// result word: reports read the held statistics, samples the updated ones
	always_comb begin
		if (item_q.op == OP_REPORT) begin
			out_d.status       = STAT_REPORT;
			out_d.run_length   = run_q;
			out_d.sample_count = cnt_q;
			out_d.above_count  = above_q;
			out_d.highest      = max_q;
			out_d.lowest       = min_q;
			out_d.mean_value   = (state_q == ST_EMIT) ? quotient : '0;
			out_d.have_samples = cnt_q != '0;
			out_d.tripped      = trip_q;
		end else begin
			out_d.status       = sample_status;
			out_d.run_length   = run_d;
			out_d.sample_count = cnt_d;
			out_d.above_count  = above_d;
			out_d.highest      = max_d;
			out_d.lowest       = min_d;
			out_d.mean_value   = '0;
			out_d.have_samples = cnt_d != '0;
			out_d.tripped      = trip_d;
		end
	end

	// sequencer
	assign slot_free    = !out_valid_q || result_ready;
	assign sample_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		commit        = 1'b0;
		load_out      = 1'b0;
		div_req.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (item_q.op == OP_REPORT && cnt_q != '0) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end else if (slot_free) begin
					load_out = 1'b1;
					commit   = item_q.op == OP_SAMPLE;
					state_d  = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// input capture
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) item_q <= sample;
	end

	// statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			above_q <= '0;
			sum_q   <= '0;
			max_q   <= '0;
			min_q   <= '0;
			run_q   <= '0;
			trip_q  <= 1'b0;
		end else if (commit) begin
			cnt_q   <= cnt_d;
			above_q <= above_d;
			sum_q   <= sum_d;
			max_q   <= max_d;
			min_q   <= min_d;
			run_q   <= run_d;
			trip_q  <= trip_d;
		end
	end

	// mean divider
	ttm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.rsp      (div_rsp),
		.quotient (quotient)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) out_q <= out_d;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// checks
	`ASSERT_SAME(a_busy_blocks_input, state_q != ST_IDLE, !sample_ready)
	`ASSERT_NEXT(a_trip_sticky, trip_q, trip_q)
	`ASSERT_SAME(a_div_only_in_div, div_rsp.busy, state_q == ST_DIV)
	`ASSERT_SAME(a_trip_flagged, result_valid && result.status == STAT_TRIP, result.tripped)

endmodule
